// ----- hw/rtl/stopword_language_matcher_core_macros.svh -----
// Assertion helpers for the stopword matcher checker.
`ifndef STOPWORD_LANGUAGE_MATCHER_CORE_MACROS_SVH
`define STOPWORD_LANGUAGE_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SWLM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swlm check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SWLM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swlm check failed");

`endif

// ----- hw/rtl/swlm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swlm_pkg;

  localparam int NUM_LANGS_DEF      = 5;
  localparam int WORDS_PER_LANG_DEF = 256;
  localparam int MAX_WORD_BYTES_DEF = 16;

  localparam int ENTRY_BYTES    = 16;
  localparam int HALF_BITS      = 64;
  localparam int NUM_COUNT_REGS = 5;
  localparam int COUNT_W        = 9;
  localparam int MASK_W         = 5;
  localparam int STAT_W         = 32;
  localparam int FUNC_W         = 3;
  localparam int LANG_W         = 3;
  localparam int CFG_INDEX_W    = 3;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TEXT  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_END   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STATS = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_PERIOD = 8'h2e;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 en;
    logic                 half;
    logic [LANG_W-1:0]    lang;
    logic [HALF_BITS-1:0] data;
  } table_wr_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return b == CH_SPACE || b == CH_COMMA || b == CH_PERIOD || b == 8'h00;
  endfunction

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stopword_language_matcher_core.sv -----
// Load, clear and ignored requests leave busy low; a statistics read shows done in the next cycle.
// A word end runs a table sweep over all WORDS_PER_LANG entries (256 by default), all
// languages in parallel off one read port per table half, then the drain and finish states.
// A word longer than MAX_WORD_BYTES skips the sweep and goes straight to the finish state.
// Reset clears statistics, length registers and the word buffer; table contents persist.
`timescale 1ns / 1ps
`default_nettype none

module stopword_language_matcher_core import swlm_pkg::*; #(
  parameter int NUM_LANGS      = NUM_LANGS_DEF,
  parameter int WORDS_PER_LANG = WORDS_PER_LANG_DEF,
  parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [FUNC_W-1:0]      func,
  input  wire logic [LANG_W-1:0]      lang,
  input  wire logic [7:0]             entry_index,
  input  wire logic                   entry_half,
  input  wire logic [HALF_BITS-1:0]   entry_bytes,
  input  wire logic [7:0]             text_byte,
  input  wire logic [STAT_W-1:0]      time_stamp,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]     cfg_data,
  output logic                        done,
  output logic                        kind,
  output logic [MASK_W-1:0]           match_mask,
  output logic [STAT_W-1:0]           found_count,
  output logic [STAT_W-1:0]           missing_count,
  output logic [STAT_W-1:0]           token_count,
  output logic [STAT_W-1:0]           last_found_time,
  output logic [STAT_W-1:0]           last_search_time
);

  localparam int AW    = $clog2(WORDS_PER_LANG);
  localparam int LEN_W = $clog2(MAX_WORD_BYTES + 1);
  localparam int BIW   = $clog2(MAX_WORD_BYTES);
  localparam int LIW   = (NUM_LANGS > 1) ? $clog2(NUM_LANGS) : 1;
  localparam int CMPW  = (AW > COUNT_W) ? AW : COUNT_W;

  state_t state, state_next;

  logic [AW-1:0]                   scan;
  logic                            rd_valid;
  logic [AW-1:0]                   rd_idx;
  logic [NUM_LANGS-1:0]            found;
  logic [NUM_LANGS-1:0]            hit;
  logic [MAX_WORD_BYTES-1:0][7:0]  word_buf;
  logic [LEN_W-1:0]                word_len;
  logic                            too_long;
  logic                            text_seen;
  logic [STAT_W-1:0]               fin_time;
  logic                            fin_search;
  logic [COUNT_W-1:0]              count_reg [NUM_COUNT_REGS];
  logic [COUNT_W-1:0]              lane_count [NUM_LANGS];
  logic [STAT_W-1:0]               hit_cnt [NUM_LANGS];
  logic [STAT_W-1:0]               miss_cnt [NUM_LANGS];
  logic [STAT_W-1:0]               word_cnt [NUM_LANGS];
  logic [STAT_W-1:0]               hit_time [NUM_LANGS];
  logic [STAT_W-1:0]               search_time [NUM_LANGS];
  logic [MASK_W-1:0]               mask_val;

  logic       acc;
  logic       pending;
  logic       go_word;
  table_wr_t  wr;
  logic [LIW-1:0] lsel;

  assign acc       = start && !busy;
  assign pending   = (word_len != '0) || too_long;
  assign go_word   = acc && pending &&
                     ((func == FUNC_TEXT && is_delim(text_byte)) || func == FUNC_END);
  assign cfg_ready = 1'b1;
  assign lsel      = lang[LIW-1:0];

  assign wr.en   = acc && func == FUNC_LOAD && int'(lang) < NUM_LANGS &&
                   int'(entry_index) < WORDS_PER_LANG;
  assign wr.half = entry_half;
  assign wr.lang = lang;
  assign wr.data = entry_bytes;

  for (genvar g = 0; g < NUM_LANGS; g++) begin : g_lane
    if (g < NUM_COUNT_REGS) begin : g_reg
      assign lane_count[g] = count_reg[g];
    end else begin : g_none
      assign lane_count[g] = '0;
    end
  end

  always_comb begin
    mask_val = '0;
    for (int l = 0; l < NUM_LANGS; l++) begin
      if (l < MASK_W) mask_val[l] = found[l];
    end
  end

  swlm_table #(
    .NUM_LANGS      (NUM_LANGS),
    .WORDS_PER_LANG (WORDS_PER_LANG),
    .MAX_WORD_BYTES (MAX_WORD_BYTES)
  ) u_table (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (AW'(entry_index)),
    .rd_addr  (scan),
    .word_buf (word_buf),
    .word_len (word_len),
    .hit      (hit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go_word) state_next = too_long ? ST_FINISH : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (scan == AW'(WORDS_PER_LANG - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan       <= '0;
      rd_valid   <= 1'b0;
      found      <= '0;
      word_buf   <= '0;
      word_len   <= '0;
      too_long   <= 1'b0;
      text_seen  <= 1'b0;
      fin_search <= 1'b0;
      done       <= 1'b0;
      for (int i = 0; i < NUM_COUNT_REGS; i++) count_reg[i] <= '0;
      for (int l = 0; l < NUM_LANGS; l++) begin
        hit_cnt[l]     <= '0;
        miss_cnt[l]    <= '0;
        word_cnt[l]    <= '0;
        hit_time[l]    <= '0;
        search_time[l] <= '0;
      end
    end else begin
      state    <= state_next;
      done     <= 1'b0;
      rd_valid <= (state == ST_SEARCH);
      rd_idx   <= scan;

      if (state == ST_SEARCH) begin
        scan <= (scan == AW'(WORDS_PER_LANG - 1)) ? '0 : scan + 1'b1;
      end else begin
        scan <= '0;
      end

      if (rd_valid) begin
        for (int l = 0; l < NUM_LANGS; l++) begin
          if (hit[l] && CMPW'(rd_idx) < CMPW'(lane_count[l])) found[l] <= 1'b1;
        end
      end

      if (cfg_valid && cfg_ready && int'(cfg_index) < NUM_COUNT_REGS) begin
        count_reg[cfg_index] <= cfg_data;
      end

      if (go_word) begin
        fin_time <= time_stamp;
        found    <= '0;
      end

      if (acc) begin
        unique case (func)
          FUNC_LOAD: begin
          end
          FUNC_TEXT: begin
            text_seen <= 1'b1;
            fin_search <= 1'b0;
            if (!is_delim(text_byte)) begin
              if (int'(word_len) < MAX_WORD_BYTES) begin
                word_buf[word_len[BIW-1:0]] <= text_byte;
                word_len <= word_len + 1'b1;
              end else begin
                too_long <= 1'b1;
              end
            end
          end
          FUNC_END: begin
            text_seen  <= 1'b0;
            fin_search <= text_seen;
            if (!pending && text_seen) begin
              for (int l = 0; l < NUM_LANGS; l++) search_time[l] <= time_stamp;
            end
          end
          FUNC_STATS: begin
            if (int'(lang) < NUM_LANGS) begin
              done             <= 1'b1;
              kind             <= 1'b1;
              match_mask       <= '0;
              found_count      <= hit_cnt[lsel];
              missing_count    <= miss_cnt[lsel];
              token_count      <= word_cnt[lsel];
              last_found_time  <= hit_time[lsel];
              last_search_time <= search_time[lsel];
            end
          end
          FUNC_CLEAR: begin
            for (int l = 0; l < NUM_LANGS; l++) begin
              hit_cnt[l]     <= '0;
              miss_cnt[l]    <= '0;
              word_cnt[l]    <= '0;
              hit_time[l]    <= '0;
              search_time[l] <= '0;
            end
          end
          default: begin
          end
        endcase
      end

      if (state == ST_FINISH) begin
        for (int l = 0; l < NUM_LANGS; l++) begin
          word_cnt[l] <= sat_inc(word_cnt[l]);
          if (found[l]) begin
            hit_cnt[l]  <= sat_inc(hit_cnt[l]);
            hit_time[l] <= fin_time;
          end else begin
            miss_cnt[l] <= sat_inc(miss_cnt[l]);
          end
          if (fin_search) search_time[l] <= fin_time;
        end
        done             <= 1'b1;
        kind             <= 1'b0;
        match_mask       <= mask_val;
        found_count      <= '0;
        missing_count    <= '0;
        token_count      <= '0;
        last_found_time  <= '0;
        last_search_time <= '0;
        word_buf         <= '0;
        word_len         <= '0;
        too_long         <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/swlm_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swlm_table import swlm_pkg::*; #(
  parameter int NUM_LANGS      = NUM_LANGS_DEF,
  parameter int WORDS_PER_LANG = WORDS_PER_LANG_DEF,
  parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF,
  localparam int AW    = $clog2(WORDS_PER_LANG),
  localparam int LEN_W = $clog2(MAX_WORD_BYTES + 1)
) (
  input  wire logic                             clk,
  input  wire table_wr_t                        wr,
  input  wire logic [AW-1:0]                    wr_addr,
  input  wire logic [AW-1:0]                    rd_addr,
  input  wire logic [MAX_WORD_BYTES-1:0][7:0]   word_buf,
  input  wire logic [LEN_W-1:0]                 word_len,
  output logic      [NUM_LANGS-1:0]             hit
);

  localparam int ROW_W = NUM_LANGS * HALF_BITS;
  localparam int PADB  = (MAX_WORD_BYTES > ENTRY_BYTES) ? MAX_WORD_BYTES : ENTRY_BYTES;

  logic [ROW_W-1:0] mem_lo [WORDS_PER_LANG];
  logic [ROW_W-1:0] mem_hi [WORDS_PER_LANG];
  logic [ROW_W-1:0] rd_lo;
  logic [ROW_W-1:0] rd_hi;
  logic [PADB*8-1:0] buf_pad;

  always_ff @(posedge clk) begin
    if (wr.en && !wr.half) begin
      mem_lo[wr_addr][wr.lang * HALF_BITS +: HALF_BITS] <= wr.data;
    end
    if (wr.en && wr.half) begin
      mem_hi[wr_addr][wr.lang * HALF_BITS +: HALF_BITS] <= wr.data;
    end
    rd_lo <= mem_lo[rd_addr];
    rd_hi <= mem_hi[rd_addr];
  end

  assign buf_pad = (PADB*8)'(word_buf);

  always_comb begin
    logic [7:0] e;
    logic [7:0] b;
    logic       m;
    for (int l = 0; l < NUM_LANGS; l++) begin
      m = (word_len <= LEN_W'(ENTRY_BYTES)) || (LEN_W > 5 ? 1'b0 : 1'b1);
      if (int'(word_len) > ENTRY_BYTES) m = 1'b0;
      for (int k = 0; k < ENTRY_BYTES; k++) begin
        e = (k < 8) ? rd_lo[l*HALF_BITS + k*8 +: 8] : rd_hi[l*HALF_BITS + (k-8)*8 +: 8];
        b = buf_pad[k*8 +: 8];
        if (k < int'(word_len)) begin
          if (to_lower(e) != to_lower(b)) m = 1'b0;
        end else if (k == int'(word_len)) begin
          if (e != 8'h00) m = 1'b0;
        end
      end
      hit[l] = m;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/swlm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "stopword_language_matcher_core_macros.svh"

module swlm_checker import swlm_pkg::*; #(
  parameter int NUM_LANGS = NUM_LANGS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic [FUNC_W-1:0]      func,
  input wire logic [LANG_W-1:0]      lang,
  input wire logic                   done,
  input wire logic                   kind,
  input wire logic [MASK_W-1:0]      match_mask,
  input wire logic [STAT_W-1:0]      found_count,
  input wire logic [STAT_W-1:0]      missing_count,
  input wire logic [STAT_W-1:0]      token_count,
  input wire logic [STAT_W-1:0]      last_found_time,
  input wire logic [STAT_W-1:0]      last_search_time
);

  `SWLM_ASSERT_NOW(a_stats_no_mask, done && kind, match_mask == '0)
  `SWLM_ASSERT_NOW(a_word_no_stats, done && !kind, found_count == '0 && missing_count == '0 && token_count == '0 && last_found_time == '0 && last_search_time == '0)
  `SWLM_ASSERT_NEXT(a_stats_reply, start && !busy && func == FUNC_STATS && int'(lang) < NUM_LANGS, done && kind)
  `SWLM_ASSERT_NEXT(a_load_silent, start && !busy && func == FUNC_LOAD, !done && !busy)

endmodule

bind stopword_language_matcher_core swlm_checker #(.NUM_LANGS(NUM_LANGS)) u_checker (.*);

`default_nettype wire
